// ----- rtl/core/efc_pkg.sv -----
// Shared types and constants of the encoder frame checker.
`timescale 1ns / 1ps

package efc_pkg;

  // Field widths
  localparam int unsigned POS_W  = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned NBYTES = 9;

  // Default number of bargraph steps over the seen position span
  localparam int unsigned BAR_STEPS_DEF = 80;

  // Header and command bytes
  localparam logic [BYTE_W-1:0] HDR_HIGH_RES = 8'hA2;
  localparam logic [BYTE_W-1:0] HDR_LOW_RES  = 8'h1A;

  // Resolution modes
  localparam logic [MODE_W-1:0] MODE_HIGH_RES = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOW_RES  = 2'd1;

  // Link status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_CRC_ERR = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_COMM = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ACC_ERR = 2'd3;

  // Error thresholds
  localparam logic [BYTE_W-1:0] CRC_WARN_LIMIT = 8'd3;
  localparam logic [BYTE_W-1:0] CRC_DEAD_LIMIT = 8'd100;
  localparam logic [BYTE_W-1:0] JUMP_LIMIT     = 8'd2;
  localparam logic [BYTE_W-1:0] CNT_MAX        = 8'd255;

  // Jump windows per mode (exclusive bounds)
  localparam logic [POS_W-1:0] JUMP_HR_LO = 21'd2000;
  localparam logic [POS_W-1:0] JUMP_HR_HI = 21'd129000;
  localparam logic [POS_W-1:0] JUMP_LR_LO = 21'd50;
  localparam logic [POS_W-1:0] JUMP_LR_HI = 21'd8100;

  // Reset value of the low position mark
  localparam logic [POS_W-1:0] LOW_MARK_RST = 21'd200000;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TRACK,
    S_SPAN_GO,
    S_SPAN_RUN,
    S_BAR_GO,
    S_BAR_RUN,
    S_EMIT
  } efc_state_t;

endpackage

// ----- rtl/core/efc_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module efc_div #(
  parameter int unsigned W = efc_pkg::POS_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       shifted;
  logic [W:0]       trial;
  logic             fits;

  // One shift-and-subtract step
  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    fits     = (shifted >= {1'b0, dvs_r});
    trial    = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[W-1:0] : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold operands
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/encoder_frame_checker_top.sv -----
// Top level of the encoder frame checker: sequencer, tracking state and output register.
`timescale 1ns / 1ps

// Encoder frame checker.
// in_* channel: one 9-byte encoder reply frame per item (byte 0 in the lowest bits,
// check byte last). The frame's XOR is checked, the position decoded per the
// resolution mode, jump and checksum errors counted, min/max marks tracked and a
// bargraph value computed.
// out_* channel: one result item per frame with position, status, error counts,
// bargraph value, next command byte and the two position marks.
// cfg_*: write enable and data for the resolution mode; write it only while idle.
// Steps: a frame passes S_CHECK and S_TRACK; a zero position then goes straight to S_EMIT,
// else S_SPAN_GO and S_SPAN_RUN follow, and a span below BAR_STEPS goes on to S_EMIT.
// Otherwise S_BAR_GO and S_BAR_RUN make one pass through the one-bit-per-cycle divider
// (position over the bargraph divisor) before S_EMIT; the span is scaled by BAR_STEPS
// with a constant reciprocal multiply in one step.
// A frame is accepted only while the sequencer is idle, so a new frame is not taken
// before the block is through with the last one. The finished result sits in the output
// register, so the next frame may be accepted while it waits; a stalled receiver
// holds the block in its last step until the output register is free.
// Reset (synchronous, rst_n low) clears all counters, the high mark and status, sets the
// low mark to LOW_MARK_RST and selects the high-resolution mode.
module encoder_frame_checker_top #(
  parameter int unsigned BAR_STEPS = efc_pkg::BAR_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // frame_byte0..frame_byte7, frame_check (8 bits each, from bit 0 up)
  input  logic [71:0]  in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // position(21), status_code(2), crc_fail_count(8), jump_fail_count(8),
  // bar_position(8), next_command(8), position_low_mark(21),
  // position_high_mark(21), zero pad(7)
  output logic [103:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_wdata
);

  localparam int unsigned POS_W  = efc_pkg::POS_W;
  localparam int unsigned BYTE_W = efc_pkg::BYTE_W;
  localparam int unsigned DIV_W  = $clog2(((2 ** POS_W) - 1) / BAR_STEPS + 1);
  // Reciprocal of BAR_STEPS, exact for any POS_W-bit span with up to 8-bit steps
  localparam int unsigned RECIP_K = POS_W + 8;
  localparam int unsigned RECIP_W = RECIP_K + 1;
  localparam int unsigned PROD_W  = POS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] BAR_RECIP =
    RECIP_W'(((64'd1 << RECIP_K) + 64'(BAR_STEPS) - 64'd1) / 64'(BAR_STEPS));

  efc_pkg::efc_state_t state_r, state_nxt;

  logic [efc_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [BYTE_W-1:0]          frame_r [efc_pkg::NBYTES];
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [POS_W-1:0]           prev_r, prev_nxt;
  logic [POS_W-1:0]           low_r, low_nxt;
  logic [POS_W-1:0]           high_r, high_nxt;
  logic [POS_W-1:0]           span_r, span_nxt;
  logic [DIV_W-1:0]           bar_div_r, bar_div_nxt;
  logic [BYTE_W-1:0]          bar_r, bar_nxt;
  logic [BYTE_W-1:0]          crc_cnt_r, crc_cnt_nxt;
  logic [BYTE_W-1:0]          jump_cnt_r, jump_cnt_nxt;
  logic [efc_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic                       jchk_r, jchk_nxt;
  logic [POS_W-1:0]           win_lo_r, win_lo_nxt;
  logic [POS_W-1:0]           win_hi_r, win_hi_nxt;
  logic [103:0]               out_data_r, out_data_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [BYTE_W-1:0] xsum;
  logic [POS_W-1:0]  mag;
  logic [BYTE_W-1:0] cnt_inc;
  logic [PROD_W-1:0] span_prod;
  logic [DIV_W-1:0]  span_quot;
  logic              div_start;
  logic [POS_W-1:0]  div_dividend;
  logic [POS_W-1:0]  div_divisor;
  logic              div_done;
  logic [POS_W-1:0]  div_quot;
  logic [BYTE_W-1:0] next_cmd;
  logic              in_acc;

  assign in_tready = (state_r == efc_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  efc_div #(
    .W (POS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = cfg_we ? cfg_wdata : mode_r;
    pos_nxt       = pos_r;
    prev_nxt      = prev_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    span_nxt      = span_r;
    bar_div_nxt   = bar_div_r;
    bar_nxt       = bar_r;
    crc_cnt_nxt   = crc_cnt_r;
    jump_cnt_nxt  = jump_cnt_r;
    stat_nxt      = stat_r;
    jchk_nxt      = jchk_r;
    win_lo_nxt    = win_lo_r;
    win_hi_nxt    = win_hi_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    div_dividend  = pos_r;
    div_divisor   = POS_W'(bar_div_r);
    cnt_inc       = '0;
    next_cmd      = (mode_r == efc_pkg::MODE_LOW_RES) ? efc_pkg::HDR_LOW_RES
                                                      : efc_pkg::HDR_HIGH_RES;

    xsum = '0;
    for (int i = 0; i < 8; i++) begin
      xsum = xsum ^ frame_r[i];
    end
    mag = (prev_r >= pos_r) ? (prev_r - pos_r) : (pos_r - prev_r);

    // Span over bargraph steps by reciprocal multiply
    span_prod = PROD_W'(span_r) * PROD_W'(BAR_RECIP);
    span_quot = span_prod[RECIP_K +: DIV_W];

    // Drop the result once the receiver takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      efc_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = efc_pkg::S_CHECK;
        end
      end

      // Checksum, then decode on a good frame
      efc_pkg::S_CHECK: begin
        jchk_nxt = 1'b0;
        prev_nxt = pos_r;
        if (xsum != frame_r[8]) begin
          cnt_inc     = (crc_cnt_r == efc_pkg::CNT_MAX) ? crc_cnt_r : crc_cnt_r + 1'b1;
          crc_cnt_nxt = cnt_inc;
          if (cnt_inc > efc_pkg::CRC_WARN_LIMIT && stat_r != efc_pkg::STAT_NO_COMM) begin
            stat_nxt = efc_pkg::STAT_CRC_ERR;
          end
          if (cnt_inc > efc_pkg::CRC_DEAD_LIMIT) begin
            stat_nxt = efc_pkg::STAT_NO_COMM;
          end
        end else if (mode_r == efc_pkg::MODE_HIGH_RES) begin
          jchk_nxt   = 1'b1;
          win_lo_nxt = efc_pkg::JUMP_HR_LO;
          win_hi_nxt = efc_pkg::JUMP_HR_HI;
          if (frame_r[0] == efc_pkg::HDR_HIGH_RES) begin
            pos_nxt = {frame_r[4], frame_r[3], frame_r[2][7:3]};
          end
        end else if (mode_r == efc_pkg::MODE_LOW_RES) begin
          jchk_nxt   = 1'b1;
          win_lo_nxt = efc_pkg::JUMP_LR_LO;
          win_hi_nxt = efc_pkg::JUMP_LR_HI;
          if (frame_r[0] == efc_pkg::HDR_LOW_RES) begin
            pos_nxt = {5'd0, frame_r[3], frame_r[2]};
          end
        end
        state_nxt = efc_pkg::S_TRACK;
      end

      // Jump test and position marks
      efc_pkg::S_TRACK: begin
        if (jchk_r && mag > win_lo_r && mag < win_hi_r) begin
          cnt_inc      = (jump_cnt_r == efc_pkg::CNT_MAX) ? jump_cnt_r : jump_cnt_r + 1'b1;
          jump_cnt_nxt = cnt_inc;
          if (cnt_inc > efc_pkg::JUMP_LIMIT) begin
            stat_nxt = efc_pkg::STAT_ACC_ERR;
          end
        end
        if (pos_r > high_r) begin
          high_nxt = pos_r;
        end
        if (pos_r < low_r) begin
          low_nxt = pos_r;
        end
        state_nxt = (pos_r != '0) ? efc_pkg::S_SPAN_GO : efc_pkg::S_EMIT;
      end

      // Register the span of the marks
      efc_pkg::S_SPAN_GO: begin
        span_nxt  = (high_r >= low_r) ? (high_r - low_r) : '0;
        state_nxt = efc_pkg::S_SPAN_RUN;
      end

      // Load the bargraph divisor
      efc_pkg::S_SPAN_RUN: begin
        bar_div_nxt = span_quot;
        state_nxt   = (span_quot != '0) ? efc_pkg::S_BAR_GO : efc_pkg::S_EMIT;
      end

      // Position over the new divisor
      efc_pkg::S_BAR_GO: begin
        div_start = 1'b1;
        state_nxt = efc_pkg::S_BAR_RUN;
      end

      efc_pkg::S_BAR_RUN: begin
        if (div_done) begin
          bar_nxt   = div_quot[BYTE_W-1:0];
          state_nxt = efc_pkg::S_EMIT;
        end
      end

      // Load the output register when it is free
      efc_pkg::S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {7'd0, high_r, low_r, next_cmd, bar_r, jump_cnt_r, crc_cnt_r,
                           stat_r, pos_r};
          out_valid_nxt = 1'b1;
          state_nxt     = efc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = efc_pkg::S_IDLE;
      end
    endcase
  end

  // Hold control and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= efc_pkg::S_IDLE;
      mode_r      <= efc_pkg::MODE_HIGH_RES;
      pos_r       <= '0;
      low_r       <= efc_pkg::LOW_MARK_RST;
      high_r      <= '0;
      bar_div_r   <= DIV_W'(1);
      bar_r       <= '0;
      crc_cnt_r   <= '0;
      jump_cnt_r  <= '0;
      stat_r      <= efc_pkg::STAT_OK;
      jchk_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      bar_div_r   <= bar_div_nxt;
      bar_r       <= bar_nxt;
      crc_cnt_r   <= crc_cnt_nxt;
      jump_cnt_r  <= jump_cnt_nxt;
      stat_r      <= stat_nxt;
      jchk_r      <= jchk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the frame and hold payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < efc_pkg::NBYTES; i++) begin
        frame_r[i] <= in_tdata[i*BYTE_W +: BYTE_W];
      end
    end
    prev_r     <= prev_nxt;
    span_r     <= span_nxt;
    win_lo_r   <= win_lo_nxt;
    win_hi_r   <= win_hi_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule
